### hdl/irom_pkg.sv
// Shared types, constants and helper functions for the Roman numeral encoder.
package irom_pkg;

  localparam int unsigned VALUE_W = 12;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned DIGITS  = 4;

  localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

  localparam logic [1:0] DIG_ONES = 2'd0;
  localparam logic [1:0] DIG_TENS = 2'd1;
  localparam logic [1:0] DIG_HUND = 2'd2;
  localparam logic [1:0] DIG_THOU = 2'd3;

  localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
  localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
  localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
  localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
  localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
  localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
  localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
  localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic                      invalid;
    logic [DIGITS-1:0][3:0]    digits;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  function automatic logic [13:0] digit_scale(logic [1:0] idx);
    logic [13:0] s;
    case (idx)
      DIG_THOU: s = 14'd1000;
      DIG_HUND: s = 14'd100;
      DIG_TENS: s = 14'd10;
      default:  s = 14'd1;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] digit_len(digit_t d);
    logic [2:0] n;
    if (d < 4'd4) begin
      n = d[2:0];
    end else if (d == 4'd4) begin
      n = 3'd2;
    end else if (d < 4'd9) begin
      n = 3'(d - 4'd4);
    end else begin
      n = 3'd2;
    end
    return n;
  endfunction

  function automatic logic [SYM_W-1:0] roman_sym(logic [1:0] idx, digit_t d, logic [1:0] pos);
    logic [SYM_W-1:0] unit;
    logic [SYM_W-1:0] five;
    logic [SYM_W-1:0] ten;
    logic [SYM_W-1:0] s;
    case (idx)
      DIG_THOU: begin
        unit = SYM_M; five = SYM_M; ten = SYM_M;
      end
      DIG_HUND: begin
        unit = SYM_C; five = SYM_D; ten = SYM_M;
      end
      DIG_TENS: begin
        unit = SYM_X; five = SYM_L; ten = SYM_C;
      end
      default: begin
        unit = SYM_I; five = SYM_V; ten = SYM_X;
      end
    endcase
    if (d < 4'd4) begin
      s = unit;
    end else if (d == 4'd4) begin
      s = (pos == 2'd0) ? unit : five;
    end else if (d < 4'd9) begin
      s = (pos == 2'd0) ? five : unit;
    end else begin
      s = (pos == 2'd0) ? unit : ten;
    end
    return s;
  endfunction

endpackage

### hdl/irom_front.sv
// Front end: accepts a value, flags it invalid or splits it into decimal digits.
module irom_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [irom_pkg::VALUE_W-1:0]   in_value,
  output logic                           busy,
  input  irom_pkg::fifo_stat_t           fifo_stat,
  output logic                           push,
  output irom_pkg::entry_t               push_entry
);
  import irom_pkg::*;

  front_state_t         state_r, state_nxt;
  logic [VALUE_W-1:0]   rem_r, rem_nxt;
  logic [1:0]           stage_r, stage_nxt;
  entry_t               ent_r, ent_nxt;
  logic [13:0]          scale;
  logic [13:0]          rem_ext;
  logic [13:0]          rem_sub;
  digit_t               dig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    stage_r <= stage_nxt;
    ent_r   <= ent_nxt;
  end

  always_comb begin
    scale   = digit_scale(stage_r);
    rem_ext = 14'(rem_r);
    dig     = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_ext >= scale * 14'(k)) begin
        dig = 4'(k);
      end
    end
    rem_sub = rem_ext - 14'(dig) * scale;
  end

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    stage_nxt  = stage_r;
    ent_nxt    = ent_r;
    busy       = 1'b1;
    push       = 1'b0;
    push_entry = ent_r;
    case (state_r)
      FR_IDLE: begin
        busy = 1'b0;
        if (start) begin
          rem_nxt         = in_value;
          stage_nxt       = DIG_THOU;
          ent_nxt.invalid = (in_value == '0) || (in_value > MAX_VALID);
          state_nxt       = FR_CONV;
        end
      end
      FR_CONV: begin
        ent_nxt.digits[stage_r] = dig;
        rem_nxt                 = rem_sub[VALUE_W-1:0];
        if (stage_r == DIG_TENS) begin
          ent_nxt.digits[DIG_ONES] = rem_sub[3:0];
          state_nxt                = FR_PUSH;
        end else begin
          stage_nxt = stage_r - 2'd1;
        end
      end
      FR_PUSH: begin
        if (!fifo_stat.full) begin
          push      = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

endmodule

### hdl/irom_fifo.sv
// Two-entry queue that carries converted digits from the front end to the back end.
module irom_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  irom_pkg::entry_t      push_entry,
  input  logic                  pop,
  output irom_pkg::entry_t      head,
  output irom_pkg::fifo_stat_t  stat
);
  import irom_pkg::*;

  entry_t      mem [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
    stat.full  = (count_r == 2'd2);
    stat.empty = (count_r == 2'd0);
    head       = mem[rd_ptr_r];
  end

endmodule

### hdl/irom_back.sv
// Back end: one Roman symbol per cycle from queued digits, none at a zero.
module irom_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irom_pkg::fifo_stat_t          fifo_stat,
  input  irom_pkg::entry_t              head,
  output logic                          pop,
  output logic                          out_valid,
  output logic [irom_pkg::SYM_W-1:0]    out_symbol,
  output logic                          out_last,
  output logic                          out_invalid
);
  import irom_pkg::*;

  back_state_t        state_r, state_nxt;
  entry_t             ent_r, ent_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [1:0]         pos_r, pos_nxt;
  logic               valid_r, valid_nxt;
  logic [SYM_W-1:0]   symbol_r, symbol_nxt;
  logic               last_r, last_nxt;
  logic               invalid_r, invalid_nxt;
  digit_t             dig;
  logic [2:0]         len;
  logic               end_of_digit;
  logic               lower_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r     <= ent_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    symbol_r  <= symbol_nxt;
    last_r    <= last_nxt;
    invalid_r <= invalid_nxt;
  end

  always_comb begin
    dig          = ent_r.digits[idx_r];
    len          = digit_len(dig);
    end_of_digit = ({1'b0, pos_r} == (len - 3'd1));
    lower_zero   = 1'b1;
    for (int i = 0; i < DIGITS - 1; i++) begin
      if ((2'(i) < idx_r) && (ent_r.digits[i] != 4'd0)) begin
        lower_zero = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    pop         = 1'b0;
    valid_nxt   = 1'b0;
    symbol_nxt  = symbol_r;
    last_nxt    = last_r;
    invalid_nxt = invalid_r;
    case (state_r)
      BK_IDLE: begin
        if (!fifo_stat.empty) begin
          pop       = 1'b1;
          ent_nxt   = head;
          idx_nxt   = DIG_THOU;
          pos_nxt   = 2'd0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (ent_r.invalid) begin
          valid_nxt   = 1'b1;
          symbol_nxt  = SYM_NONE;
          last_nxt    = 1'b1;
          invalid_nxt = 1'b1;
          state_nxt   = BK_IDLE;
        end else if (dig == 4'd0) begin
          idx_nxt = idx_r - 2'd1;
          pos_nxt = 2'd0;
          if (idx_r == DIG_ONES) begin
            state_nxt = BK_IDLE;
          end
        end else begin
          valid_nxt   = 1'b1;
          symbol_nxt  = roman_sym(idx_r, dig, pos_r);
          last_nxt    = end_of_digit && lower_zero;
          invalid_nxt = 1'b0;
          if (end_of_digit && lower_zero) begin
            state_nxt = BK_IDLE;
          end else if (end_of_digit) begin
            idx_nxt = idx_r - 2'd1;
            pos_nxt = 2'd0;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_valid   = valid_r;
  assign out_symbol  = symbol_r;
  assign out_last    = last_r;
  assign out_invalid = invalid_r;

endmodule

### hdl/integer_to_roman_encoder_core.sv
// Top level of the integer to Roman numeral encoder.
//
// A value is handed over with start while busy is low; that cycle is the transfer.
// The front end checks the range, splits the value into four decimal digits
// (thousands, then hundreds, then tens together with ones) and pushes the
// result; busy stays high from the transfer until the push, which waits while
// the two-entry queue to the back end is full; no new value is taken until the
// last one has been pushed. The back end takes one queued entry only while idle,
// loads it and then emits one symbol per cycle, except that each zero digit ahead
// of the last nonzero digit is skipped without a symbol, leading zeros delaying
// the first symbol; 3888 gives the longest output. When the back end is free,
// the first symbol of a value of 1000 or more, or the single invalid result,
// follows the transfer through the front end's digit steps and push, the queue,
// the back end's load and its output register.
// Each symbol is shown on out_symbol for one cycle with out_valid high; out_last
// marks the final symbol. A value of 0 or above 3999 gives a single transfer with
// out_invalid and out_last high and out_symbol zero.
// The receiver cannot stall, so symbols are never held back once emitted.
// A synchronous reset empties the queue and returns both ends to idle.
module integer_to_roman_encoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [irom_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  output logic [irom_pkg::SYM_W-1:0]    out_symbol,
  output logic                          out_last,
  output logic                          out_invalid
);
  import irom_pkg::*;

  fifo_stat_t  fifo_stat;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      head;

  irom_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_value   (in_value),
    .busy       (busy),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  irom_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (fifo_stat)
  );

  irom_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fifo_stat   (fifo_stat),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_symbol  (out_symbol),
    .out_last    (out_last),
    .out_invalid (out_invalid)
  );

endmodule

### hdl/irom_checker.sv
// Port-level checker for the Roman numeral encoder and its bind statement.
module irom_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [irom_pkg::SYM_W-1:0]    out_symbol,
  input logic                          out_last,
  input logic                          out_invalid
);
  import irom_pkg::*;

  a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_last && (out_symbol == SYM_NONE))
    else $error("invalid transfer must be a single zero symbol");

  a_valid_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |->
      (out_symbol == SYM_I) || (out_symbol == SYM_V) || (out_symbol == SYM_X) ||
      (out_symbol == SYM_L) || (out_symbol == SYM_C) || (out_symbol == SYM_D) ||
      (out_symbol == SYM_M))
    else $error("symbol is not a Roman numeral character");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("front end must be busy after a transfer");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output strobe high right after reset");

endmodule

bind integer_to_roman_encoder_core irom_checker u_irom_checker (.*);
